FILE: rtl/camr_pkg.sv
// ----------------------------------------------------------------------------
// camr_pkg
// shared types and constants for the pinhole camera ray generator
// ----------------------------------------------------------------------------
package camr_pkg;

    // configuration register map
    typedef enum logic [2:0] {
        REG_HALF_EXTENTS = 3'd0,
        REG_PIXEL_PITCH  = 3'd1,
        REG_ROW0_LEFT    = 3'd2,
        REG_ROW0_RIGHT   = 3'd3,
        REG_ROW1_LEFT    = 3'd4,
        REG_ROW1_RIGHT   = 3'd5,
        REG_ROW2_LEFT    = 3'd6,
        REG_ROW2_RIGHT   = 3'd7
    } cfg_reg_t;

    localparam int CFG_IDX_BITS = 3;
    localparam int MAT_WORDS    = 6;

    // the largest normalized magnitude lies in [2^NORM_EXP, 2^(NORM_EXP+1)), the others below
    localparam int NORM_EXP   = 29;
    localparam int NORM_BITS  = NORM_EXP + 1;
    localparam int ABS_BITS   = 63;
    localparam int LEAD_BITS  = 6;
    localparam int SQ_BITS    = 2 * NORM_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    // one root digit per stage, starting at 4^(ISQ_STEPS-1)
    localparam int ISQ_STEPS  = SUM_BITS / 2;
    localparam int LEN_BITS   = 32;

    // position of the highest set bit
    function automatic logic [LEAD_BITS-1:0] lead_pos(input logic [ABS_BITS-1:0] val);
        logic [LEAD_BITS-1:0] pos;
        pos = '0;
        for (int i = 0; i < ABS_BITS; i++) begin
            if (val[i]) begin
                pos = LEAD_BITS'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: rtl/camera_ray_generator_core.sv
// ----------------------------------------------------------------------------
// camera_ray_generator_core
// pinhole camera primary ray generator, one ray per pixel
// ----------------------------------------------------------------------------
// usage
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) loads the half
//    extents, pixel pitch and the 3x4 camera-to-world matrix; cfg_ready is
//    always high; the user writes only while no pixel is in flight (not enforced)
//  - s_ channel carries one pixel (x, y) per transfer
//  - m_ channel returns the ray origin (matrix translation column, Q16.16)
//    and the unit direction (signed Q1.FRAC_BITS)
//  - throughput: one pixel per cycle unless the receiver stalls, fully pipelined
//  - depth: 9 front stages + ISQ_STEPS root stages + FRAC_BITS+2 divider
//    stages + output register; the bit-serial square root and the
//    restoring divider set that depth
//  - a zero direction vector gives a zero direction
//  - reset clears the configuration registers and all valid bits
//  - when the receiver stalls with a result waiting, the whole pipe holds and
//    s_tready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module camera_ray_generator_core
    import camr_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int FRAC_BITS        = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [63:0]                   cfg_data,
    // pixel input: pixel_x, pixel_y
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((2*PIXEL_COORD_BITS+7)/8)*8-1:0] s_tdata,
    // ray output: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [((96+3*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);

    localparam int PW        = PIXEL_COORD_BITS;
    localparam int PROD_BITS = PW + 33;
    localparam int NUM_BITS  = PW + 35;
    localparam int DS        = FRAC_BITS + 2;
    localparam int OUT_RAW   = 96 + 3 * DS;
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [63:0] half_reg;
    logic [31:0] pitch_reg;
    logic [63:0] mat_reg [0:MAT_WORDS-1];
    logic [CFG_IDX_BITS-1:0] mat_idx;

    assign cfg_ready = 1'b1;
    assign mat_idx   = cfg_index - CFG_IDX_BITS'(REG_ROW0_LEFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg  <= '0;
            pitch_reg <= '0;
            for (int i = 0; i < MAT_WORDS; i++) begin
                mat_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HALF_EXTENTS: half_reg <= cfg_data;
                REG_PIXEL_PITCH:  pitch_reg <= cfg_data[31:0];
                default:          mat_reg[mat_idx] <= cfg_data;
            endcase
        end
    end

    // matrix coefficients, m[r][c]
    logic signed [31:0] m_coef [0:2][0:3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            m_coef[r][0] = $signed(mat_reg[2*r][63:32]);
            m_coef[r][1] = $signed(mat_reg[2*r][31:0]);
            m_coef[r][2] = $signed(mat_reg[2*r+1][63:32]);
            m_coef[r][3] = $signed(mat_reg[2*r+1][31:0]);
        end
    end

    // global advance: the pipe moves unless a result waits at the output
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    logic [PW-1:0] pix [0:1];
    assign pix[0] = s_tdata[PW-1:0];
    assign pix[1] = s_tdata[2*PW-1:PW];

    // ------------------------------------------------------------------
    // stage 1: (2p+1) * pitch
    // ------------------------------------------------------------------
    logic                 p1_valid_reg;
    logic [PROD_BITS-1:0] p1_prod_reg [0:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 2; i++) begin
                p1_prod_reg[i] <= PROD_BITS'({pix[i], 1'b1}) * PROD_BITS'(pitch_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: world coordinates, floor halving and saturation
    // ------------------------------------------------------------------
    logic               p2_valid_reg;
    logic signed [31:0] p2_w_reg [0:1];
    logic signed [NUM_BITS-1:0] num [0:1];
    logic signed [NUM_BITS-1:0] half_num [0:1];
    logic signed [31:0]         w_next [0:1];
    logic [31:0]                half_val [0:1];

    assign half_val[0] = half_reg[63:32];
    assign half_val[1] = half_reg[31:0];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            num[i] = $signed({{(NUM_BITS-33){1'b0}}, half_val[i], 1'b0})
                   - $signed({2'b00, p1_prod_reg[i]});
            half_num[i] = num[i] >>> 1;
            if (half_num[i][NUM_BITS-1:31] == {(NUM_BITS-31){half_num[i][31]}}) begin
                w_next[i] = half_num[i][31:0];
            end else if (half_num[i][NUM_BITS-1]) begin
                w_next[i] = 32'sh8000_0000;
            end else begin
                w_next[i] = 32'sh7fff_ffff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_w_reg <= w_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: matrix products, the z term is a shift
    // ------------------------------------------------------------------
    logic               p3_valid_reg;
    logic signed [63:0] p3_prod_reg [0:2][0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                p3_prod_reg[r][0] <= 64'(m_coef[r][0]) * 64'(p2_w_reg[0]);
                p3_prod_reg[r][1] <= 64'(m_coef[r][1]) * 64'(p2_w_reg[1]);
                p3_prod_reg[r][2] <= -(64'(m_coef[r][2]) <<< FRAC_BITS);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: floor quarter of each product, summed per row
    // ------------------------------------------------------------------
    logic               p4_valid_reg;
    logic signed [63:0] p4_v_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                p4_v_reg[r] <= (p3_prod_reg[r][0] >>> 2) + (p3_prod_reg[r][1] >>> 2)
                             + (p3_prod_reg[r][2] >>> 2);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 5: magnitudes and their maximum
    // ------------------------------------------------------------------
    logic                p5_valid_reg;
    logic [ABS_BITS-1:0] p5_a_reg [0:2];
    logic [2:0]          p5_neg_reg;
    logic [ABS_BITS-1:0] p5_max_reg;
    logic [ABS_BITS-1:0] abs_v [0:2];
    logic [63:0]         neg_v [0:2];
    logic [ABS_BITS-1:0] max_01;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            neg_v[r] = 64'(-p4_v_reg[r]);
            abs_v[r] = p4_v_reg[r][63] ? neg_v[r][ABS_BITS-1:0] : p4_v_reg[r][ABS_BITS-1:0];
        end
        max_01 = (abs_v[0] > abs_v[1]) ? abs_v[0] : abs_v[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_valid_reg <= 1'b0;
        end else if (en) begin
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_a_reg   <= abs_v;
            p5_max_reg <= (max_01 > abs_v[2]) ? max_01 : abs_v[2];
            for (int r = 0; r < 3; r++) begin
                p5_neg_reg[r] <= p4_v_reg[r][63];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 6: leading one of the maximum
    // ------------------------------------------------------------------
    logic                 p6_valid_reg;
    logic [ABS_BITS-1:0]  p6_a_reg [0:2];
    logic [2:0]           p6_neg_reg;
    logic                 p6_zero_reg;
    logic [LEAD_BITS-1:0] p6_lead_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p6_valid_reg <= 1'b0;
        end else if (en) begin
            p6_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p6_a_reg    <= p5_a_reg;
            p6_neg_reg  <= p5_neg_reg;
            p6_zero_reg <= (p5_max_reg == '0);
            p6_lead_reg <= lead_pos(p5_max_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 7: common normalizing shift
    // ------------------------------------------------------------------
    logic                 p7_valid_reg;
    logic [NORM_BITS-1:0] p7_a_reg [0:2];
    logic [2:0]           p7_neg_reg;
    logic                 p7_zero_reg;
    logic [ABS_BITS-1:0]  shifted [0:2];
    logic [LEAD_BITS-1:0] shamt;
    logic                 shift_right;

    always_comb begin
        shift_right = (p6_lead_reg >= LEAD_BITS'(NORM_EXP));
        shamt = shift_right ? (p6_lead_reg - LEAD_BITS'(NORM_EXP))
                            : (LEAD_BITS'(NORM_EXP) - p6_lead_reg);
        for (int r = 0; r < 3; r++) begin
            shifted[r] = shift_right ? (p6_a_reg[r] >> shamt) : (p6_a_reg[r] << shamt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p7_valid_reg <= 1'b0;
        end else if (en) begin
            p7_valid_reg <= p6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                p7_a_reg[r] <= shifted[r][NORM_BITS-1:0];
            end
            p7_neg_reg  <= p6_neg_reg;
            p7_zero_reg <= p6_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: squares
    // ------------------------------------------------------------------
    logic                 p8_valid_reg;
    logic [SQ_BITS-1:0]   p8_sq_reg [0:2];
    logic [NORM_BITS-1:0] p8_a_reg [0:2];
    logic [2:0]           p8_neg_reg;
    logic                 p8_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p8_valid_reg <= 1'b0;
        end else if (en) begin
            p8_valid_reg <= p7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                p8_sq_reg[r] <= SQ_BITS'(p7_a_reg[r]) * SQ_BITS'(p7_a_reg[r]);
            end
            p8_a_reg    <= p7_a_reg;
            p8_neg_reg  <= p7_neg_reg;
            p8_zero_reg <= p7_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: sum of squares
    // ------------------------------------------------------------------
    logic                 p9_valid_reg;
    logic [SUM_BITS-1:0]  p9_sum_reg;
    logic [NORM_BITS-1:0] p9_a_reg [0:2];
    logic [2:0]           p9_neg_reg;
    logic                 p9_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p9_valid_reg <= 1'b0;
        end else if (en) begin
            p9_valid_reg <= p8_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p9_sum_reg  <= SUM_BITS'(p8_sq_reg[0]) + SUM_BITS'(p8_sq_reg[1])
                         + SUM_BITS'(p8_sq_reg[2]);
            p9_a_reg    <= p8_a_reg;
            p9_neg_reg  <= p8_neg_reg;
            p9_zero_reg <= p8_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // square root, one result digit per stage
    // ------------------------------------------------------------------
    logic                 sq_valid_reg [0:ISQ_STEPS-1];
    logic [SUM_BITS-1:0]  sq_n_reg     [0:ISQ_STEPS-1];
    logic [SUM_BITS-1:0]  sq_r_reg     [0:ISQ_STEPS-1];
    logic [NORM_BITS-1:0] sq_a_reg     [0:ISQ_STEPS-1][0:2];
    logic [2:0]           sq_neg_reg   [0:ISQ_STEPS-1];
    logic                 sq_zero_reg  [0:ISQ_STEPS-1];

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isqrt
        localparam logic [SUM_BITS-1:0] BIT = SUM_BITS'(1) << (2 * (ISQ_STEPS - 1 - k));
        logic                 valid_in;
        logic [SUM_BITS-1:0]  n_in;
        logic [SUM_BITS-1:0]  r_in;
        logic [NORM_BITS-1:0] a_in [0:2];
        logic [2:0]           neg_in;
        logic                 zero_in;
        logic [SUM_BITS-1:0]  trial;

        if (k == 0) begin : g_first
            assign valid_in = p9_valid_reg;
            assign n_in     = p9_sum_reg;
            assign r_in     = '0;
            assign a_in     = p9_a_reg;
            assign neg_in   = p9_neg_reg;
            assign zero_in  = p9_zero_reg;
        end else begin : g_next
            assign valid_in = sq_valid_reg[k-1];
            assign n_in     = sq_n_reg[k-1];
            assign r_in     = sq_r_reg[k-1];
            assign a_in     = sq_a_reg[k-1];
            assign neg_in   = sq_neg_reg[k-1];
            assign zero_in  = sq_zero_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (n_in >= trial) begin
                    sq_n_reg[k] <= n_in - trial;
                    sq_r_reg[k] <= (r_in >> 1) + BIT;
                end else begin
                    sq_n_reg[k] <= n_in;
                    sq_r_reg[k] <= r_in >> 1;
                end
                sq_a_reg[k]    <= a_in;
                sq_neg_reg[k]  <= neg_in;
                sq_zero_reg[k] <= zero_in;
            end
        end
    end

    logic [LEN_BITS-1:0] len;
    assign len = sq_r_reg[ISQ_STEPS-1][LEN_BITS-1:0];

    // ------------------------------------------------------------------
    // restoring divider, a * 2^(FRAC_BITS+1) / len, one quotient bit per
    // stage in each of the three lanes
    // ------------------------------------------------------------------
    logic                dv_valid_reg [0:DS-1];
    logic [LEN_BITS-1:0] dv_len_reg   [0:DS-1];
    logic [LEN_BITS-1:0] dv_rem_reg   [0:DS-1][0:2];
    logic [DS-1:0]       dv_q_reg     [0:DS-1][0:2];
    logic [2:0]          dv_neg_reg   [0:DS-1];
    logic                dv_zero_reg  [0:DS-1];

    for (genvar k = 0; k < DS; k++) begin : g_div
        logic                valid_in;
        logic [LEN_BITS-1:0] len_in;
        logic [LEN_BITS:0]   part [0:2];
        logic [DS-1:0]       q_in [0:2];
        logic [2:0]          neg_in;
        logic                zero_in;

        if (k == 0) begin : g_first
            assign valid_in = sq_valid_reg[ISQ_STEPS-1];
            assign len_in   = len;
            assign neg_in   = sq_neg_reg[ISQ_STEPS-1];
            assign zero_in  = sq_zero_reg[ISQ_STEPS-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign part[l] = (LEN_BITS+1)'(sq_a_reg[ISQ_STEPS-1][l]);
                assign q_in[l] = '0;
            end
        end else begin : g_next
            assign valid_in = dv_valid_reg[k-1];
            assign len_in   = dv_len_reg[k-1];
            assign neg_in   = dv_neg_reg[k-1];
            assign zero_in  = dv_zero_reg[k-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign part[l] = {dv_rem_reg[k-1][l], 1'b0};
                assign q_in[l] = dv_q_reg[k-1][l];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < 3; l++) begin
                    if (part[l] >= {1'b0, len_in}) begin
                        dv_rem_reg[k][l] <= LEN_BITS'(part[l] - {1'b0, len_in});
                        dv_q_reg[k][l]   <= {q_in[l][DS-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[k][l] <= part[l][LEN_BITS-1:0];
                        dv_q_reg[k][l]   <= {q_in[l][DS-2:0], 1'b0};
                    end
                end
                dv_len_reg[k]  <= len_in;
                dv_neg_reg[k]  <= neg_in;
                dv_zero_reg[k] <= zero_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: round half up, clamp to one, restore the sign
    // ------------------------------------------------------------------
    localparam logic [DS-1:0] UNIT = DS'(1) << FRAC_BITS;

    logic [DS-1:0] dir_reg  [0:2];
    logic [DS-1:0] dir_next [0:2];
    logic [DS:0]   q_inc    [0:2];
    logic [DS-1:0] mag      [0:2];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            q_inc[l] = {1'b0, dv_q_reg[DS-1][l]} + (DS+1)'(1);
            mag[l]   = q_inc[l][DS:1];
            if (mag[l] > UNIT) begin
                mag[l] = UNIT;
            end
            if (dv_zero_reg[DS-1]) begin
                dir_next[l] = '0;
            end else if (dv_neg_reg[DS-1][l]) begin
                dir_next[l] = DS'(-mag[l]);
            end else begin
                dir_next[l] = mag[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid_reg[DS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dir_reg <= dir_next;
        end
    end

    // origin is the translation column; the user keeps it constant while pixels are in flight, not enforced
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({dir_reg[2], dir_reg[1], dir_reg[0],
                              m_coef[2][3], m_coef[1][3], m_coef[0][3]});

endmodule
